### rtl/core/gtjm_pkg.sv
// Shared types and constants for the gamepad to joystick/mouse mapper.
// No dependencies; every other file of the block imports this package.
package gtjm_pkg;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] MOUSE_STEP_RESET = 4'd4;

  localparam logic [8:0] SCREEN_X_MAX = 9'd319;
  localparam logic [7:0] SCREEN_Y_MAX = 8'd239;

  localparam logic [6:0] KEY_SPACE  = 7'd64;
  localparam logic [6:0] KEY_RETURN = 7'd68;
  localparam logic [6:0] KEY_ESCAPE = 7'd69;

  // Key event slots, emitted lowest first.
  localparam int KEV_X_PRESS     = 0;
  localparam int KEV_X_RELEASE   = 1;
  localparam int KEV_Y_PRESS     = 2;
  localparam int KEV_Y_RELEASE   = 3;
  localparam int KEV_START_PRESS = 4;
  localparam int KEV_START_REL   = 5;
  localparam int KEV_N           = 6;

  typedef struct packed {
    logic btn_option;
    logic btn_menu;
    logic btn_select;
    logic btn_start;
    logic btn_y;
    logic btn_x;
    logic btn_b;
    logic btn_a;
    logic pad_right;
    logic pad_left;
    logic pad_down;
    logic pad_up;
  } poll_t;

  typedef struct packed {
    logic       key_valid;
    logic [6:0] key_code;
    logic       key_release;
    logic [9:0] joy_direction;
    logic       joy_fire;
    logic [8:0] cursor_x;
    logic [7:0] cursor_y;
    logic       mouse_left;
    logic       mouse_right;
    logic       open_game_menu;
    logic       open_options_menu;
    logic       last;
  } result_t;

  // One classified poll: pending key events plus the status fields.
  typedef struct packed {
    logic [KEV_N-1:0] key_mask;
    logic [9:0]       joy_direction;
    logic             joy_fire;
    logic [8:0]       cursor_x;
    logic [7:0]       cursor_y;
    logic             mouse_left;
    logic             mouse_right;
    logic             open_game_menu;
    logic             open_options_menu;
  } rec_t;

endpackage

### rtl/core/gtjm_if.sv
// Channel interfaces of the mapper: poll input, result output, step register.
// Depends on gtjm_pkg.
interface gtjm_poll_if;
  import gtjm_pkg::*;
  logic  valid;
  logic  ready;
  poll_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtjm_result_if;
  import gtjm_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gtjm_cfg_if;
  import gtjm_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/gtjm_front.sv
// Front end: accepts polls, tracks button/mode/cursor state and classifies
// each poll into one queue record. Depends on gtjm_pkg and gtjm_if.
module gtjm_front (
  input  logic             clk,
  input  logic             rst,
  gtjm_poll_if.sink        poll,
  gtjm_cfg_if.sink         cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output gtjm_pkg::rec_t   push_data
);
  import gtjm_pkg::*;

  logic [STEP_W-1:0] mouse_step;
  poll_t             prev;
  logic              chord;
  logic              mode;
  logic [8:0]        pos_x;
  logic [7:0]        pos_y;

  logic              chord_next;
  logic              mode_next;
  logic [8:0]        pos_x_next;
  logic [7:0]        pos_y_next;
  poll_t             joy;
  logic              accept;
  logic              others_held;
  logic              top;
  logic              bot;
  logic signed [10:0] sx;
  logic signed [9:0]  sy;
  logic signed [10:0] stepx;
  logic signed [9:0]  stepy;

  assign joy        = poll.data;
  assign poll.ready = push_ready;
  assign push_valid = poll.valid;
  assign accept     = poll.valid && push_ready;
  assign cfg.ready  = 1'b1;

  assign others_held = |(joy & ~poll_t'({1'b0, 1'b1, 10'b0}));

  always_comb begin
    push_data  = '0;
    chord_next = chord;
    if (joy.btn_menu) begin
      if (others_held) chord_next = 1'b1;
    end else if (prev.btn_menu) begin
      push_data.open_game_menu = !chord;
      chord_next = 1'b0;
    end
    push_data.open_options_menu = joy.btn_option && !prev.btn_option;
    mode_next = mode ^ (joy.btn_select && !prev.btn_select);

    push_data.key_mask[KEV_X_PRESS]     = joy.btn_x && !prev.btn_x;
    push_data.key_mask[KEV_X_RELEASE]   = !joy.btn_x && prev.btn_x;
    push_data.key_mask[KEV_Y_PRESS]     = joy.btn_y && !prev.btn_y;
    push_data.key_mask[KEV_Y_RELEASE]   = !joy.btn_y && prev.btn_y;
    push_data.key_mask[KEV_START_PRESS] = joy.btn_start && !prev.btn_start;
    push_data.key_mask[KEV_START_REL]   = !joy.btn_start && prev.btn_start;

    // Cursor move, full range first, then clamp to the screen in mouse mode
    stepx = signed'({7'b0, mouse_step});
    stepy = signed'({6'b0, mouse_step});
    sx = signed'({2'b00, pos_x});
    sy = signed'({2'b00, pos_y});
    if (joy.pad_left)  sx = sx - stepx;
    if (joy.pad_right) sx = sx + stepx;
    if (joy.pad_up)    sy = sy - stepy;
    if (joy.pad_down)  sy = sy + stepy;

    top = joy.pad_up ^ joy.pad_left;
    bot = joy.pad_down ^ joy.pad_right;
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    if (!mode_next) begin
      push_data.joy_direction = {joy.pad_left, top, 6'b0, joy.pad_right, bot};
      push_data.joy_fire      = joy.btn_a || joy.btn_b;
      push_data.mouse_left    = joy.btn_a || joy.btn_b;
    end else begin
      if (sx < 0)                              pos_x_next = '0;
      else if (sx > signed'({2'b00, SCREEN_X_MAX})) pos_x_next = SCREEN_X_MAX;
      else                                     pos_x_next = sx[8:0];
      if (sy < 0)                              pos_y_next = '0;
      else if (sy > signed'({2'b00, SCREEN_Y_MAX})) pos_y_next = SCREEN_Y_MAX;
      else                                     pos_y_next = sy[7:0];
      push_data.mouse_left  = joy.btn_b;
      push_data.mouse_right = joy.btn_a;
    end
    push_data.cursor_x = pos_x_next;
    push_data.cursor_y = pos_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_step <= MOUSE_STEP_RESET;
      prev       <= '0;
      chord      <= 1'b0;
      mode       <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
    end else begin
      if (cfg.valid) mouse_step <= cfg.data;
      if (accept) begin
        prev  <= joy;
        chord <= chord_next;
        mode  <= mode_next;
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

  a_pos_on_screen: assert property (@(posedge clk) disable iff (rst)
    pos_x <= SCREEN_X_MAX && pos_y <= SCREEN_Y_MAX)
    else $error("cursor off screen");

endmodule

### rtl/core/gtjm_queue.sv
// Short record queue between front and back ends.
// Depends on gtjm_pkg.
module gtjm_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  gtjm_pkg::rec_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gtjm_pkg::rec_t pop_data
);
  import gtjm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop_fire)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push_fire && !pop_fire)      count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue overfilled");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_fire && !pop_fire) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

### rtl/core/gtjm_back.sv
// Back end: expands each queued record into its key events and a final
// status item, one per cycle while result is ready, through an output register.
// Depends on gtjm_pkg and gtjm_if.
module gtjm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  gtjm_pkg::rec_t pop_data,
  gtjm_result_if.source  result
);
  import gtjm_pkg::*;

  logic [KEV_N-1:0] done;
  logic [KEV_N-1:0] done_next;
  logic [KEV_N-1:0] pending;
  logic [KEV_N-1:0] sel;
  logic             load;
  logic             out_valid;
  result_t          out_data;
  result_t          item;

  assign load      = !out_valid || result.ready;
  assign pending   = pop_data.key_mask & ~done;
  assign sel       = pending & (~pending + 1'b1);
  assign pop_ready = load && (pending == '0);

  always_comb begin
    item      = '0;
    done_next = done;
    if (pending != '0) begin
      item.key_valid   = 1'b1;
      item.key_release = sel[KEV_X_RELEASE] || sel[KEV_Y_RELEASE] || sel[KEV_START_REL];
      if (sel[KEV_X_PRESS] || sel[KEV_X_RELEASE])      item.key_code = KEY_SPACE;
      else if (sel[KEV_Y_PRESS] || sel[KEV_Y_RELEASE]) item.key_code = KEY_RETURN;
      else                                             item.key_code = KEY_ESCAPE;
      done_next = done | sel;
    end else begin
      item.joy_direction     = pop_data.joy_direction;
      item.joy_fire          = pop_data.joy_fire;
      item.cursor_x          = pop_data.cursor_x;
      item.cursor_y          = pop_data.cursor_y;
      item.mouse_left        = pop_data.mouse_left;
      item.mouse_right       = pop_data.mouse_right;
      item.open_game_menu    = pop_data.open_game_menu;
      item.open_options_menu = pop_data.open_options_menu;
      item.last              = 1'b1;
      done_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else if (load) begin
      out_valid <= pop_valid;
      if (pop_valid) done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) out_data <= item;
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_last_xor_key: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last != out_data.key_valid))
    else $error("item is neither key nor status");

  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> ((done & ~pop_data.key_mask) == '0))
    else $error("emitted key not in current record");

endmodule

### rtl/core/gamepad_to_joystick_mouse_mapper.sv
// Top level of the gamepad to joystick/mouse mapper.
// Depends on gtjm_pkg, gtjm_if, gtjm_front, gtjm_queue and gtjm_back.
//
//   channel  dir  payload                 transfer when
//   poll     in   poll_t, 12 buttons      poll.valid & poll.ready
//   result   out  result_t, key or status result.valid & result.ready
//   cfg      in   mouse_step, 4 bits      cfg.valid & cfg.ready (always ready)
//
// A poll yields 1 to 4 results (one per key event, then status), one per
// cycle from the output register while the result side is not stalled.
// The front end takes a poll every cycle while the record queue has room.
// rst is synchronous; it clears state, queue and output valid, step to 4.
// Stalls on result back up through the queue to poll.ready.
module gamepad_to_joystick_mouse_mapper #(
  parameter int QueueDepth = 4
) (
  input  logic          clk,
  input  logic          rst,
  gtjm_poll_if.sink     poll,
  gtjm_cfg_if.sink      cfg,
  gtjm_result_if.source result
);
  import gtjm_pkg::*;

  logic push_valid;
  logic push_ready;
  rec_t push_data;
  logic pop_valid;
  logic pop_ready;
  rec_t pop_data;

  gtjm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  gtjm_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gtjm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
